// ----- rtl/bhu_pkg.sv -----
// shared types and constants of the butterfly history update block
package bhu_pkg;

  // field widths
  localparam int unsigned FUNC_BITS   = 2;
  localparam int unsigned SQUARE_BITS = 6;
  localparam int unsigned DEPTH_BITS  = 8;
  localparam int unsigned SCORE_BITS  = 16;
  localparam int unsigned BONUS_BITS  = 16;
  localparam int unsigned LIMIT_BITS  = 15;
  localparam int unsigned SCALE_BITS  = 11;
  localparam int unsigned OFFSET_BITS = 12;
  localparam int unsigned PROD_BITS   = SCALE_BITS + DEPTH_BITS;

  // score table geometry
  localparam int unsigned TABLE_DEPTH = 8192;
  localparam int unsigned ADDR_BITS   = $clog2(TABLE_DEPTH);

  // default entry width
  localparam int unsigned ENTRY_BITS_DEF = 16;

  // command queue depth, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration reset values
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 15'd16384;
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 11'd256;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 12'd128;

  // configuration register indexes
  localparam logic [1:0] REG_HISTORY_LIMIT = 2'd0;
  localparam logic [1:0] REG_DEPTH_SCALE   = 2'd1;
  localparam logic [1:0] REG_DEPTH_OFFSET  = 2'd2;

  // largest score magnitude on the result channel
  localparam int SCORE_MAX = 32767;

  // operation codes
  localparam logic [FUNC_BITS-1:0] FUNC_READ     = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_REWARD   = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_PENALIZE = 2'd2;

  // classified command from front to back
  typedef struct packed {
    logic                          upd;
    logic [ADDR_BITS-1:0]          addr;
    logic signed [BONUS_BITS-1:0]  bonus;
    logic [LIMIT_BITS-1:0]         mag;
  } bhu_cmd_t;

endpackage

// ----- rtl/bhu_in_if.sv -----
// request channel carrying one history operation
interface bhu_in_if;
  logic                               valid;
  logic                               ready;
  logic [bhu_pkg::FUNC_BITS-1:0]      func;
  logic                               side;
  logic [bhu_pkg::SQUARE_BITS-1:0]    from_square;
  logic [bhu_pkg::SQUARE_BITS-1:0]    to_square;
  logic [bhu_pkg::DEPTH_BITS-1:0]     depth;

  modport source (output valid, func, side, from_square, to_square, depth, input ready);
  modport sink   (input valid, func, side, from_square, to_square, depth, output ready);
endinterface

// ----- rtl/bhu_out_if.sv -----
// result channel carrying one score
interface bhu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bhu_pkg::SCORE_BITS-1:0] score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface

// ----- rtl/bhu_ram.sv -----
// generic single-port-write ram with registered read
module bhu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bhu_front.sv -----
// front end: accepts requests, forms the clamped bonus and classifies them
module bhu_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            enable_i,
  input  logic [bhu_pkg::LIMIT_BITS-1:0]  limit_i,
  input  logic [bhu_pkg::SCALE_BITS-1:0]  scale_i,
  input  logic [bhu_pkg::OFFSET_BITS-1:0] offset_i,
  bhu_in_if.sink                          item_i,
  output bhu_pkg::bhu_cmd_t               cmd_o,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i
);
  import bhu_pkg::*;

  localparam int unsigned RAW_BITS = PROD_BITS + 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_CLAMP
  } fstate_e;

  fstate_e state_q, state_d;

  logic [FUNC_BITS-1:0]  func_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [DEPTH_BITS-1:0] depth_q;
  logic [PROD_BITS-1:0]  prod_q;

  logic                       accept;
  logic signed [RAW_BITS-1:0] raw;
  logic signed [RAW_BITS-1:0] lim_s;
  logic signed [RAW_BITS-1:0] clamped;
  logic signed [RAW_BITS-1:0] signed_bonus;
  logic signed [RAW_BITS-1:0] abs_bonus;

  assign item_i.ready = (state_q == F_IDLE) && enable_i;
  assign accept       = item_i.valid && item_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_MUL;
      F_MUL:   state_d = F_CLAMP;
      F_CLAMP: if (cmd_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture and scaled depth
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= item_i.func;
      addr_q  <= {item_i.side, item_i.from_square, item_i.to_square};
      depth_q <= item_i.depth;
    end
    if (state_q == F_MUL) begin
      prod_q <= PROD_BITS'(scale_i * depth_q);
    end
  end

  // subtract offset and clamp to the limit
  always_comb begin
    raw   = signed'({2'b00, prod_q}) - signed'(RAW_BITS'(offset_i));
    lim_s = signed'(RAW_BITS'(limit_i));
    if (raw > lim_s) begin
      clamped = lim_s;
    end else if (raw < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = raw;
    end
    signed_bonus = (func_q == FUNC_PENALIZE) ? -clamped : clamped;
    abs_bonus    = clamped[RAW_BITS-1] ? -clamped : clamped;
  end

  assign cmd_valid_o = (state_q == F_CLAMP);
  assign cmd_o.upd   = (func_q == FUNC_REWARD) || (func_q == FUNC_PENALIZE);
  assign cmd_o.addr  = addr_q;
  assign cmd_o.bonus = signed_bonus[BONUS_BITS-1:0];
  assign cmd_o.mag   = abs_bonus[LIMIT_BITS-1:0];

endmodule

// ----- rtl/bhu_queue.sv -----
// short command queue between front and back
module bhu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  bhu_pkg::bhu_cmd_t push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output bhu_pkg::bhu_cmd_t pop_data_o,
  input  logic              pop_ready_i
);
  import bhu_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);

  bhu_cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wptr_q, rptr_q;
  logic [PTR_BITS:0]    count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/bhu_back.sv -----
// back end: clears the table, reads an entry, applies the gravity update
module bhu_back #(
  parameter int unsigned ENTRY_BITS = bhu_pkg::ENTRY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bhu_pkg::LIMIT_BITS-1:0] limit_i,
  input  bhu_pkg::bhu_cmd_t              cmd_i,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  output logic                           init_done_o,
  bhu_out_if.source                      result_o
);
  import bhu_pkg::*;

  localparam int unsigned EB   = ENTRY_BITS;
  localparam int unsigned SW   = ((EB > BONUS_BITS) ? EB : BONUS_BITS) + 2;
  localparam int unsigned MW   = EB + LIMIT_BITS;
  localparam int unsigned CW   = $clog2(EB);
  localparam logic signed [SW-1:0] EMAX = {{(SW-EB+1){1'b0}}, {(EB-1){1'b1}}};
  localparam logic signed [SW-1:0] EMIN = {{(SW-EB+1){1'b1}}, {(EB-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = SW'(SCORE_MAX);
  localparam logic signed [SW-1:0] SMIN = -SMAX;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_MUL,
    B_DIV,
    B_FIN
  } bstate_e;

  bstate_e state_q, state_d;
  logic [ADDR_BITS-1:0] clr_addr_q;
  logic [CW-1:0]        cnt_q;
  logic                 out_valid_q, out_valid_d;

  bhu_cmd_t                cmd_q;
  logic signed [EB-1:0]    entry_q;
  logic [LIMIT_BITS-1:0]   rem_q;
  logic [EB-1:0]           qr_q;
  logic signed [SCORE_BITS-1:0] score_q;

  logic                  ram_we, ram_re;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [EB-1:0]         ram_wdata, ram_rdata;

  logic                  pop, finish;
  logic [EB-1:0]         abs_entry;
  logic [MW-1:0]         prod;
  logic [LIMIT_BITS+1:0] trial;
  logic                  fits;
  logic [SW-1:0]         q_ext;
  logic signed [SW-1:0]  gravity, sum, res_ext;
  logic [EB-1:0]         upd_val, res_val;
  logic [SCORE_BITS-1:0] score_val;

  assign pop         = (state_q == B_IDLE) && cmd_valid_i;
  assign cmd_ready_o = (state_q == B_IDLE);
  assign init_done_o = (state_q != B_CLEAR);
  assign finish      = (state_q == B_FIN) && (!out_valid_q || result_o.ready);

  // table storage
  bhu_ram #(
    .WIDTH (EB),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cmd_i.addr),
    .rdata_o (ram_rdata)
  );

  // table write: zero sweep after reset, else update write-back
  always_comb begin
    ram_re    = pop;
    ram_we    = (state_q == B_CLEAR) || (finish && cmd_q.upd);
    ram_waddr = (state_q == B_CLEAR) ? clr_addr_q : cmd_q.addr;
    ram_wdata = (state_q == B_CLEAR) ? '0 : upd_val;
  end

  // magnitude product and one restoring division step
  always_comb begin
    abs_entry = entry_q[EB-1] ? EB'(-entry_q) : EB'(entry_q);
    prod      = MW'(abs_entry * cmd_q.mag);
    trial     = {1'b0, rem_q, qr_q[EB-1]} - {2'b00, limit_i};
    fits      = !trial[LIMIT_BITS+1];
  end

  // new entry value and saturations
  always_comb begin
    q_ext   = {{(SW-EB){1'b0}}, qr_q};
    gravity = entry_q[EB-1] ? -signed'(q_ext) : signed'(q_ext);
    sum     = signed'({{(SW-EB){entry_q[EB-1]}}, entry_q})
            + signed'({{(SW-BONUS_BITS){cmd_q.bonus[BONUS_BITS-1]}}, cmd_q.bonus})
            - gravity;
    if (sum > EMAX) begin
      upd_val = EMAX[EB-1:0];
    end else if (sum < EMIN) begin
      upd_val = EMIN[EB-1:0];
    end else begin
      upd_val = sum[EB-1:0];
    end
    res_val = cmd_q.upd ? upd_val : entry_q;
    res_ext = signed'({{(SW-EB){res_val[EB-1]}}, res_val});
    if (res_ext > SMAX) begin
      score_val = SMAX[SCORE_BITS-1:0];
    end else if (res_ext < SMIN) begin
      score_val = SMIN[SCORE_BITS-1:0];
    end else begin
      score_val = res_ext[SCORE_BITS-1:0];
    end
  end

  // next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && result_o.ready) out_valid_d = 1'b0;
    case (state_q)
      B_CLEAR: if (clr_addr_q == '1) state_d = B_IDLE;
      B_IDLE:  if (pop) state_d = B_READ;
      B_READ:  state_d = cmd_q.upd ? B_MUL : B_FIN;
      B_MUL:   state_d = B_DIV;
      B_DIV:   if (cnt_q == '0) state_d = B_FIN;
      B_FIN: begin
        if (finish) begin
          state_d     = B_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == B_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      if (state_q == B_MUL) begin
        cnt_q <= CW'(EB - 1);
      end else if (state_q == B_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop) cmd_q <= cmd_i;
    if (state_q == B_READ) entry_q <= signed'(ram_rdata);
    if (state_q == B_MUL) begin
      rem_q <= prod[MW-1:EB];
      qr_q  <= prod[EB-1:0];
    end else if (state_q == B_DIV) begin
      rem_q <= fits ? trial[LIMIT_BITS-1:0] : {rem_q[LIMIT_BITS-2:0], qr_q[EB-1]};
      qr_q  <= {qr_q[EB-2:0], fits};
    end
    if (finish) score_q <= signed'(score_val);
  end

  assign result_o.valid = out_valid_q;
  assign result_o.score = score_q;

endmodule

// ----- rtl/butterfly_history_update.sv -----
// top level of the butterfly history score table with gravity update
//
//   channel   direction  handshake             payload
//   item_i    in         valid/ready           func, side, from_square, to_square, depth
//   result_o  out        valid/ready           score
//   apb       in         psel/penable/pready   paddr, pwdata, prdata
//
// after reset the table is swept to zero; no request is taken then.
// the bit-serial divider by the limit in the back end sets the pace; the front end takes
// a new request only once it has handed the last one on and, with its two-entry queue,
// keeps taking them while the back end works or the result register waits for its sink.
module butterfly_history_update #(
  parameter int unsigned ENTRY_BITS = bhu_pkg::ENTRY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bhu_in_if.sink      item_i,
  bhu_out_if.source   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bhu_pkg::*;

  logic [LIMIT_BITS-1:0]  limit_q;
  logic [SCALE_BITS-1:0]  scale_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [LIMIT_BITS-1:0]  lim_eff;
  logic                   wr;

  bhu_cmd_t front_cmd, back_cmd;
  logic     front_valid, front_ready, back_valid, back_ready;
  logic     init_done;

  // configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      scale_q  <= SCALE_RESET;
      offset_q <= OFFSET_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_HISTORY_LIMIT: limit_q  <= pwdata[LIMIT_BITS-1:0];
        REG_DEPTH_SCALE:   scale_q  <= pwdata[SCALE_BITS-1:0];
        REG_DEPTH_OFFSET:  offset_q <= pwdata[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[3:2])
      REG_HISTORY_LIMIT: prdata = 32'(limit_q);
      REG_DEPTH_SCALE:   prdata = 32'(scale_q);
      REG_DEPTH_OFFSET:  prdata = 32'(offset_q);
      default:           prdata = '0;
    endcase
  end

  // a zero limit behaves as one
  assign lim_eff = (limit_q == '0) ? LIMIT_BITS'(1) : limit_q;

  bhu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (init_done),
    .limit_i     (lim_eff),
    .scale_i     (scale_q),
    .offset_i    (offset_q),
    .item_i      (item_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  bhu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_data_i  (front_cmd),
    .push_ready_o (front_ready),
    .pop_valid_o  (back_valid),
    .pop_data_o   (back_cmd),
    .pop_ready_i  (back_ready)
  );

  bhu_back #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (lim_eff),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .init_done_o (init_done),
    .result_o    (result_o)
  );

endmodule
